// ===== hw/rtl/srt_pkg.sv =====
`default_nettype none

package srt_pkg;

	// Default sizing of the tracker.
	localparam int ENTRIES_DEF     = 16;
	localparam int LENGTH_BITS_DEF = 24;
	localparam int MAX_SEGMENT_DEF = 66000;

	// Field widths of the segment header and the result.
	localparam int NODE_W    = 32;
	localparam int PORT_W    = 32;
	localparam int TRANS_W   = 32;
	localparam int SEG_W     = 16;
	localparam int TOTAL_W   = 24;
	localparam int PAYLOAD_W = 17;
	localparam int STATUS_W  = 3;
	localparam int INDEX_W   = 4;
	localparam int OFFSET_W  = 24;
	localparam int ACKLEN_W  = 24;

	// Stream widths, rounded up to whole bytes.
	localparam int IN_BITS  = NODE_W + PORT_W + TRANS_W + SEG_W + TOTAL_W + PAYLOAD_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STATUS_W + INDEX_W + OFFSET_W + TRANS_W + ACKLEN_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Sequence number that opens a transaction.
	localparam logic [SEG_W-1:0] FIRST_SEG = SEG_W'(1);

	// Result codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED  = 3'd0,
		ST_COMPLETED = 3'd1,
		ST_NO_START  = 3'd2,
		ST_GAP       = 3'd3,
		ST_FULL      = 3'd4,
		ST_OVERRUN   = 3'd5
	} srt_status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE
	} srt_state_t;

	// One segment header.
	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		logic [TOTAL_W-1:0]   total;
		logic [SEG_W-1:0]     seg;
		logic [TRANS_W-1:0]   trans;
		logic [PORT_W-1:0]    port;
		logic [NODE_W-1:0]    node;
	} srt_req_t;

	// Outcome of one segment: result fields plus table update controls.
	typedef struct packed {
		srt_status_t         status;
		logic [OFFSET_W-1:0] offset;
		logic [TRANS_W-1:0]  ack_id;
		logic [ACKLEN_W-1:0] ack_len;
		logic                write;
		logic                clear;
	} srt_act_t;

endpackage

`default_nettype wire

// ===== hw/rtl/segment_reassembly_tracker_top.sv =====
`default_nettype none

// Segment reassembly tracker. Each segment header transfer on the s_ side yields exactly
// one result transfer on the m_ side. Transactions are kept in an ENTRIES-deep table
// memory keyed by peer node, peer port and transaction id; a header is looked up by
// reading that memory one entry per cycle, stopping at the first matching valid entry,
// and the matched or newly opened entry is then updated in the decision state once the
// result register is free. A new header is accepted only in the idle state, after the
// previous one has been decided; the single read port of the table memory is used by
// the scan. Of the table, only the valid bits are cleared at reset, so the block is
// ready right after reset.
module segment_reassembly_tracker_top
	import srt_pkg::*;
#(
	parameter int ENTRIES     = ENTRIES_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int MAX_SEGMENT = MAX_SEGMENT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// peer_node, peer_port, trans_id, seg_id, total_length, payload_length, zero pad
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// status, entry_index, write_offset, ack_trans_id, ack_length, zero pad
	output logic      [OUT_W-1:0] m_tdata
);

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int DATA_W = NODE_W + PORT_W + TRANS_W + 2 * LENGTH_BITS + SEG_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

	// Record layout in the table memory.
	localparam int NEXT_LSB  = 0;
	localparam int RCV_LSB   = NEXT_LSB + SEG_W;
	localparam int TOT_LSB   = RCV_LSB + LENGTH_BITS;
	localparam int TRANS_LSB = TOT_LSB + LENGTH_BITS;
	localparam int PORT_LSB  = TRANS_LSB + TRANS_W;
	localparam int NODE_LSB  = PORT_LSB + PORT_W;

	srt_state_t state_q, state_d;

	srt_req_t               req_q;
	logic [ENTRIES-1:0]     valid_q;
	logic [IDX_W-1:0]       scan_q;
	logic                   issue_q;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic                   hit_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic                   free_found_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic [LENGTH_BITS-1:0] ent_total_q;
	logic [LENGTH_BITS-1:0] ent_received_q;
	logic [SEG_W-1:0]       ent_next_q;
	logic                   m_tvalid_q;
	logic [OUT_W-1:0]       m_tdata_q;

	logic                   accept;
	logic                   rd_en;
	logic                   out_free;
	logic                   load_out;
	logic                   cmp_hit;
	logic                   cmp_last;
	logic [DATA_W-1:0]      rd_data;
	logic [DATA_W-1:0]      wr_data;
	srt_act_t               act;
	logic [IDX_W-1:0]       slot;
	logic [LENGTH_BITS-1:0] new_total;
	logic [LENGTH_BITS-1:0] new_received;
	logic [SEG_W-1:0]       new_next;
	logic [31:0]            slot32;
	logic [INDEX_W-1:0]     out_index;

	// Table memory.
	srt_mem #(
		.DEPTH (ENTRIES),
		.ADDR_W(IDX_W),
		.DATA_W(DATA_W)
	) u_mem (
		.clk    (clk),
		.wr_en  (load_out && act.write),
		.wr_addr(slot),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(scan_q),
		.rd_data(rd_data)
	);

	// Segment classification.
	srt_eval #(
		.IDX_W      (IDX_W),
		.LENGTH_BITS(LENGTH_BITS),
		.MAX_SEGMENT(MAX_SEGMENT)
	) u_eval (
		.req         (req_q),
		.hit         (hit_q),
		.hit_idx     (hit_idx_q),
		.free_found  (free_found_q),
		.free_idx    (free_idx_q),
		.ent_total   (ent_total_q),
		.ent_received(ent_received_q),
		.ent_next    (ent_next_q),
		.act         (act),
		.slot        (slot),
		.new_total   (new_total),
		.new_received(new_received),
		.new_next    (new_next)
	);

	assign wr_data = {req_q.node, req_q.port, req_q.trans, new_total, new_received, new_next};

	// Key compare on the entry read in the previous cycle.
	always_comb begin
		cmp_hit = rd_vld_s1 && valid_q[rd_idx_s1]
			&& rd_data[NODE_LSB +: NODE_W] == req_q.node
			&& rd_data[PORT_LSB +: PORT_W] == req_q.port
			&& rd_data[TRANS_LSB +: TRANS_W] == req_q.trans;
		cmp_last = rd_vld_s1 && rd_idx_s1 == LAST;
		out_free = !m_tvalid_q || m_tready;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (cmp_hit || cmp_last) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_IDLE:   s_tready = 1'b1;
			S_SCAN:   rd_en    = issue_q;
			S_DECIDE: load_out = out_free;
			default:  s_tready = 1'b0;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			scan_q       <= '0;
			issue_q      <= 1'b0;
			rd_vld_s1    <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (accept) begin
				scan_q       <= '0;
				issue_q      <= 1'b1;
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end
			// Walk the table addresses and note the lowest free entry.
			if (rd_en) begin
				if (scan_q != LAST) begin
					scan_q <= scan_q + IDX_W'(1);
				end
				if (!valid_q[scan_q] && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			// Reads stop after the last address or at the first match.
			if ((rd_en && scan_q == LAST) || (state_q == S_SCAN && cmp_hit)) begin
				issue_q <= 1'b0;
			end
			if (state_q == S_SCAN && cmp_hit) begin
				hit_q <= 1'b1;
			end
			// Update the valid bit of the entry used.
			if (load_out && act.write) begin
				valid_q[slot] <= 1'b1;
			end else if (load_out && act.clear) begin
				valid_q[slot] <= 1'b0;
			end
			// Result register.
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign slot32    = 32'(slot);
	assign out_index = (act.status == ST_NO_START || act.status == ST_FULL)
		? '0 : slot32[INDEX_W-1:0];

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q;
		if (accept) begin
			req_q <= s_tdata[IN_BITS-1:0];
		end
		if (rd_en && !valid_q[scan_q] && !free_found_q) begin
			free_idx_q <= scan_q;
		end
		if (state_q == S_SCAN && cmp_hit) begin
			hit_idx_q      <= rd_idx_s1;
			ent_total_q    <= rd_data[TOT_LSB +: LENGTH_BITS];
			ent_received_q <= rd_data[RCV_LSB +: LENGTH_BITS];
			ent_next_q     <= rd_data[NEXT_LSB +: SEG_W];
		end
		if (load_out) begin
			m_tdata_q <= OUT_W'({act.ack_len, act.ack_id, act.offset, out_index, act.status});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/srt_mem.sv =====
`default_nettype none

module srt_mem
	import srt_pkg::*;
#(
	parameter int DEPTH  = ENTRIES_DEF,
	parameter int ADDR_W = 4,
	parameter int DATA_W = 184
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/srt_eval.sv =====
`default_nettype none

module srt_eval
	import srt_pkg::*;
#(
	parameter int IDX_W       = 4,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int MAX_SEGMENT = MAX_SEGMENT_DEF
) (
	input  wire srt_req_t               req,
	input  wire logic                   hit,
	input  wire logic [IDX_W-1:0]       hit_idx,
	input  wire logic                   free_found,
	input  wire logic [IDX_W-1:0]       free_idx,
	input  wire logic [LENGTH_BITS-1:0] ent_total,
	input  wire logic [LENGTH_BITS-1:0] ent_received,
	input  wire logic [SEG_W-1:0]       ent_next,
	output srt_act_t                    act,
	output logic      [IDX_W-1:0]       slot,
	output logic      [LENGTH_BITS-1:0] new_total,
	output logic      [LENGTH_BITS-1:0] new_received,
	output logic      [SEG_W-1:0]       new_next
);

	localparam int SUM_W = ((LENGTH_BITS > PAYLOAD_W) ? LENGTH_BITS : PAYLOAD_W) + 1;
	localparam logic [PAYLOAD_W-1:0] MAX_PAY = PAYLOAD_W'(MAX_SEGMENT);

	logic [LENGTH_BITS-1:0] off;
	logic [LENGTH_BITS-1:0] tot;
	logic [SEG_W-1:0]       expect_seg;
	logic [SUM_W-1:0]       sum;
	logic [SUM_W-1:0]       tot_ext;
	logic [31:0]            off32;
	logic [31:0]            tot32;

	// A fresh entry starts empty and expects the first segment.
	always_comb begin
		slot       = hit ? hit_idx : free_idx;
		off        = hit ? ent_received : '0;
		tot        = hit ? ent_total : LENGTH_BITS'(req.total);
		expect_seg = hit ? ent_next : FIRST_SEG;
		sum        = SUM_W'(off) + SUM_W'(req.payload);
		tot_ext    = SUM_W'(tot);
		off32      = 32'(off);
		tot32      = 32'(tot);
	end

	// Record written back for a segment that keeps the entry open.
	always_comb begin
		new_total    = tot;
		new_received = LENGTH_BITS'(sum);
		new_next     = expect_seg + SEG_W'(1);
	end

	// Classify the segment.
	always_comb begin
		act.status  = ST_ACCEPTED;
		act.offset  = '0;
		act.ack_id  = '0;
		act.ack_len = '0;
		act.write   = 1'b0;
		act.clear   = 1'b0;
		if (!hit && req.seg != FIRST_SEG) begin
			act.status = ST_NO_START;
		end else if (!hit && !free_found) begin
			act.status = ST_FULL;
		end else if (req.seg != expect_seg) begin
			act.status = ST_GAP;
		end else if (req.payload > MAX_PAY || sum > tot_ext) begin
			act.status = ST_OVERRUN;
			act.offset = off32[OFFSET_W-1:0];
		end else if (sum == tot_ext) begin
			act.status  = ST_COMPLETED;
			act.offset  = off32[OFFSET_W-1:0];
			act.ack_id  = req.trans;
			act.ack_len = tot32[ACKLEN_W-1:0];
			act.clear   = 1'b1;
		end else begin
			act.status = ST_ACCEPTED;
			act.offset = off32[OFFSET_W-1:0];
			act.write  = 1'b1;
		end
	end

endmodule

`default_nettype wire
